// ===== hdl/scfp_pkg.sv =====
// Shared types, character codes, keyword tables and helper functions
// for the serial command frame parser. No dependencies.
`default_nettype none

package scfp_pkg;

    // command codes carried on the result channel
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_SET_SPEED = 3'd1;
    localparam logic [2:0] CMD_GET_DATA  = 3'd2;
    localparam logic [2:0] CMD_SET_AUTO  = 3'd3;
    localparam logic [2:0] CMD_TOO_LONG  = 3'd4;

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;

    // keyword tables, position index saturates at KW_MAX_LEN
    localparam int KW_COUNT   = 3;
    localparam int KW_MAX_LEN = 8;
    localparam int POS_W      = 4;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h73, 8'h65, 8'h74, 8'h53, 8'h70, 8'h65, 8'h65, 8'h64},  // setSpeed
        '{8'h67, 8'h65, 8'h74, 8'h44, 8'h61, 8'h74, 8'h61, 8'h00},  // getData
        '{8'h73, 8'h65, 8'h74, 8'h41, 8'h75, 8'h74, 8'h6F, 8'h00}   // setAuto
    };
    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{4'd8, 4'd7, 4'd7};
    localparam logic [2:0] KW_CODE [KW_COUNT] = '{CMD_SET_SPEED, CMD_GET_DATA, CMD_SET_AUTO};

    // body position where the numeric arguments start
    localparam logic [POS_W-1:0] ARG_START = 4'd8;

    // saturation limits of the magnitude and the signed result
    localparam logic [15:0] MAG_LIMIT = 16'd32768;
    localparam logic [15:0] POS_LIMIT = 16'd32767;

    // argument scanner phases
    typedef enum logic [2:0] {
        PH_M_WS   = 3'd0,
        PH_M_SIGN = 3'd1,
        PH_M_DIG  = 3'd2,
        PH_S_WS   = 3'd3,
        PH_S_SIGN = 3'd4,
        PH_S_DIG  = 3'd5,
        PH_DONE   = 3'd6
    } arg_phase_t;

    // per-byte control from the frame logic to the sub-blocks
    typedef struct packed {
        logic step;
        logic clear;
    } scfp_ctrl_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return (c == CHAR_PLUS) || (c == CHAR_MINUS);
    endfunction

    // mag * 10 + digit, saturated at 32768
    function automatic logic [15:0] acc_digit(input logic [15:0] mag, input logic [7:0] c);
        logic [18:0] v;
        v = {mag, 3'b000} + {2'b00, mag, 1'b0} + {15'd0, 4'(c - CHAR_ZERO)};
        return (v > {3'b000, MAG_LIMIT}) ? MAG_LIMIT : v[15:0];
    endfunction

    // magnitude and sign to clamped 16-bit two's complement
    function automatic logic [15:0] to_signed(input logic [15:0] mag, input logic neg);
        if (neg) begin
            return 16'(16'd0 - mag);
        end
        return (mag > POS_LIMIT) ? POS_LIMIT : mag;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scfp_kw_match.sv =====
// Keyword matcher: tracks which of the three keywords still match the body
// prefix and picks the command code at frame close. Uses scfp_pkg.
`default_nettype none

module scfp_kw_match (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire scfp_pkg::scfp_ctrl_t        ctrl,
    input  wire logic [7:0]                  rx_byte,
    input  wire logic [scfp_pkg::POS_W-1:0]  pos,
    output logic [2:0]                       kw_code
);

    logic [scfp_pkg::KW_COUNT-1:0] alive_reg;
    logic [scfp_pkg::KW_COUNT-1:0] alive_next;

    // drop keywords whose letter at this position differs
    always_comb begin
        alive_next = alive_reg;
        if (ctrl.clear) begin
            alive_next = '1;
        end else if (ctrl.step) begin
            for (int k = 0; k < scfp_pkg::KW_COUNT; k++) begin
                if ((pos < scfp_pkg::KW_LEN[k]) &&
                    (rx_byte != scfp_pkg::KW_TEXT[k][pos[2:0]])) begin
                    alive_next[k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= '1;
        end else begin
            alive_reg <= alive_next;
        end
    end

    // first keyword that is alive and fully seen wins
    always_comb begin
        kw_code = scfp_pkg::CMD_NONE;
        for (int k = scfp_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (alive_reg[k] && (pos >= scfp_pkg::KW_LEN[k])) begin
                kw_code = scfp_pkg::KW_CODE[k];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/scfp_arg_scan.sv =====
// Argument scanner: reads two signed decimal numbers after the keyword,
// one byte per step, with saturation. Uses scfp_pkg.
`default_nettype none

module scfp_arg_scan (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire scfp_pkg::scfp_ctrl_t  ctrl,
    input  wire logic [7:0]            rx_byte,
    output logic [15:0]                motor_value,
    output logic [15:0]                speed_value
);

    scfp_pkg::arg_phase_t phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic [15:0]          motor_reg, motor_next;
    logic [15:0]          speed_reg, speed_next;

    // scanner state update
    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        motor_next = motor_reg;
        speed_next = speed_reg;
        if (ctrl.clear) begin
            phase_next = scfp_pkg::PH_M_WS;
            neg_next   = 1'b0;
            motor_next = '0;
            speed_next = '0;
        end else if (ctrl.step) begin
            if (rx_byte == scfp_pkg::CHAR_NUL) begin
                // zero byte ends the string
                if (phase_reg == scfp_pkg::PH_M_DIG) begin
                    motor_next = scfp_pkg::to_signed(motor_reg, neg_reg);
                end
                if (phase_reg == scfp_pkg::PH_S_DIG) begin
                    speed_next = scfp_pkg::to_signed(speed_reg, neg_reg);
                end
                phase_next = scfp_pkg::PH_DONE;
            end else begin
                unique case (phase_reg)
                    scfp_pkg::PH_M_WS: begin
                        if (scfp_pkg::is_ws(rx_byte)) begin
                            phase_next = phase_reg;
                        end else if (scfp_pkg::is_sign(rx_byte)) begin
                            neg_next   = (rx_byte == scfp_pkg::CHAR_MINUS);
                            phase_next = scfp_pkg::PH_M_SIGN;
                        end else if (scfp_pkg::is_dig(rx_byte)) begin
                            neg_next   = 1'b0;
                            motor_next = scfp_pkg::acc_digit(16'd0, rx_byte);
                            phase_next = scfp_pkg::PH_M_DIG;
                        end else begin
                            phase_next = scfp_pkg::PH_DONE;
                        end
                    end
                    scfp_pkg::PH_M_SIGN: begin
                        if (scfp_pkg::is_dig(rx_byte)) begin
                            motor_next = scfp_pkg::acc_digit(16'd0, rx_byte);
                            phase_next = scfp_pkg::PH_M_DIG;
                        end else begin
                            phase_next = scfp_pkg::PH_DONE;
                        end
                    end
                    scfp_pkg::PH_M_DIG: begin
                        if (scfp_pkg::is_dig(rx_byte)) begin
                            motor_next = scfp_pkg::acc_digit(motor_reg, rx_byte);
                        end else begin
                            motor_next = scfp_pkg::to_signed(motor_reg, neg_reg);
                            if (scfp_pkg::is_ws(rx_byte)) begin
                                phase_next = scfp_pkg::PH_S_WS;
                            end else if (scfp_pkg::is_sign(rx_byte)) begin
                                neg_next   = (rx_byte == scfp_pkg::CHAR_MINUS);
                                phase_next = scfp_pkg::PH_S_SIGN;
                            end else begin
                                phase_next = scfp_pkg::PH_DONE;
                            end
                        end
                    end
                    scfp_pkg::PH_S_WS: begin
                        if (scfp_pkg::is_ws(rx_byte)) begin
                            phase_next = phase_reg;
                        end else if (scfp_pkg::is_sign(rx_byte)) begin
                            neg_next   = (rx_byte == scfp_pkg::CHAR_MINUS);
                            phase_next = scfp_pkg::PH_S_SIGN;
                        end else if (scfp_pkg::is_dig(rx_byte)) begin
                            neg_next   = 1'b0;
                            speed_next = scfp_pkg::acc_digit(16'd0, rx_byte);
                            phase_next = scfp_pkg::PH_S_DIG;
                        end else begin
                            phase_next = scfp_pkg::PH_DONE;
                        end
                    end
                    scfp_pkg::PH_S_SIGN: begin
                        if (scfp_pkg::is_dig(rx_byte)) begin
                            speed_next = scfp_pkg::acc_digit(16'd0, rx_byte);
                            phase_next = scfp_pkg::PH_S_DIG;
                        end else begin
                            phase_next = scfp_pkg::PH_DONE;
                        end
                    end
                    scfp_pkg::PH_S_DIG: begin
                        if (scfp_pkg::is_dig(rx_byte)) begin
                            speed_next = scfp_pkg::acc_digit(speed_reg, rx_byte);
                        end else begin
                            speed_next = scfp_pkg::to_signed(speed_reg, neg_reg);
                            phase_next = scfp_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        phase_next = scfp_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= scfp_pkg::PH_M_WS;
            neg_reg   <= 1'b0;
            motor_reg <= '0;
            speed_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            motor_reg <= motor_next;
            speed_reg <= speed_next;
        end
    end

    // a number still in its digits is converted at frame close
    assign motor_value = (phase_reg == scfp_pkg::PH_M_DIG) ?
                         scfp_pkg::to_signed(motor_reg, neg_reg) : motor_reg;
    assign speed_value = (phase_reg == scfp_pkg::PH_S_DIG) ?
                         scfp_pkg::to_signed(speed_reg, neg_reg) : speed_reg;

endmodule

`default_nettype wire

// ===== hdl/serial_command_frame_parser_unit.sv =====
// Flow: an accepted byte is held in the input register and processed from there;
// a frame-closing ';' writes the result register, which drives m_valid.
// Throughput: one byte per cycle, set by the single frame-state update per byte;
// only a frame-closing ';' waits, while an earlier result is still untaken on the output register.
// Reset: synchronous active-low aresetn clears frame state, both valid flags and
// the keyword and argument trackers; no clearing pass.
`default_nettype none

module serial_command_frame_parser_unit #(
    parameter int MAX_BODY = 126
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_command_code,
    output logic signed [15:0]      m_motor_number,
    output logic signed [15:0]      m_motor_speed
);

    localparam int               CNT_W   = $clog2(MAX_BODY + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BODY);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;

    // frame state
    logic             in_frame_reg, in_frame_next;
    logic [CNT_W-1:0] body_count_reg, body_count_next;
    logic             overflowed_reg, overflowed_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_code_reg, out_code_next;
    logic [15:0] out_motor_reg, out_motor_next;
    logic [15:0] out_speed_reg, out_speed_next;

    logic                          is_close;
    logic                          advance;
    logic                          body_step;
    logic [scfp_pkg::POS_W-1:0]    pos;
    logic [2:0]                    kw_code;
    logic [2:0]                    code;
    logic [15:0]                   motor_value;
    logic [15:0]                   speed_value;
    scfp_pkg::scfp_ctrl_t          kw_ctrl;
    scfp_pkg::scfp_ctrl_t          arg_ctrl;

    // handshake and byte classification
    assign is_close  = in_frame_reg && (in_byte_reg == scfp_pkg::CHAR_SEMI);
    assign advance   = in_valid_reg && (!is_close || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign body_step = advance && in_frame_reg && !is_close && !overflowed_reg &&
                       (body_count_reg < MAX_CNT);
    assign pos       = (body_count_reg >= CNT_W'(scfp_pkg::ARG_START)) ?
                       scfp_pkg::ARG_START : body_count_reg[scfp_pkg::POS_W-1:0];

    assign kw_ctrl.step   = body_step;
    assign kw_ctrl.clear  = advance && is_close;
    assign arg_ctrl.step  = body_step && (pos == scfp_pkg::ARG_START);
    assign arg_ctrl.clear = advance && is_close;

    scfp_kw_match u_kw_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (kw_ctrl),
        .rx_byte (in_byte_reg),
        .pos     (pos),
        .kw_code (kw_code)
    );

    scfp_arg_scan u_arg_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (arg_ctrl),
        .rx_byte     (in_byte_reg),
        .motor_value (motor_value),
        .speed_value (speed_value)
    );

    // result selection at frame close
    assign code = overflowed_reg ? scfp_pkg::CMD_TOO_LONG : kw_code;

    // next state of input register, frame state and result register
    always_comb begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        in_frame_next   = in_frame_reg;
        body_count_next = body_count_reg;
        overflowed_next = overflowed_reg;
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_motor_next  = out_motor_reg;
        out_speed_next  = out_speed_reg;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            in_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_rx_byte;
        end

        if (advance) begin
            priority if (!in_frame_reg) begin
                if (in_byte_reg == scfp_pkg::CHAR_BANG) begin
                    in_frame_next = 1'b1;
                end
            end else if (is_close) begin
                out_valid_next  = 1'b1;
                out_code_next   = code;
                out_motor_next  = (code == scfp_pkg::CMD_SET_SPEED) ? motor_value : 16'd0;
                out_speed_next  = (code == scfp_pkg::CMD_SET_SPEED) ? speed_value : 16'd0;
                in_frame_next   = 1'b0;
                body_count_next = '0;
                overflowed_next = 1'b0;
            end else if (overflowed_reg) begin
                overflowed_next = 1'b1;
            end else if (body_count_reg >= MAX_CNT) begin
                overflowed_next = 1'b1;
            end else begin
                body_count_next = body_count_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            in_frame_reg   <= 1'b0;
            body_count_reg <= '0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            in_frame_reg   <= in_frame_next;
            body_count_reg <= body_count_next;
            overflowed_reg <= overflowed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_byte_reg   <= in_byte_next;
        out_code_reg  <= out_code_next;
        out_motor_reg <= out_motor_next;
        out_speed_reg <= out_speed_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_command_code = out_code_reg;
    assign m_motor_number = out_motor_reg;
    assign m_motor_speed  = out_speed_reg;

`ifndef SYNTHESIS
    // overflow only once the body count has reached its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        overflowed_reg |-> (body_count_reg == MAX_CNT))
        else $error("overflow flag set below body limit");

    // no body state outside a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> ((body_count_reg == '0) && !overflowed_reg))
        else $error("body state left over outside a frame");

    // only set speed carries numbers
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_command_code != scfp_pkg::CMD_SET_SPEED)) |->
        ((m_motor_number == 16'sd0) && (m_motor_speed == 16'sd0)))
        else $error("numeric fields nonzero for a command without arguments");

    // a frame close reaches the result register on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_close) |=> m_valid)
        else $error("frame close produced no transaction");
`endif

endmodule

`default_nettype wire
